// File: rtl/epwc_pkg.sv
package epwc_pkg;
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W = 3;
  localparam int PAGE_BYTES = 256;
  localparam int OFF_W = 8;
  localparam int PAGE_W = 10;
  localparam int DATA_DEPTH = NUM_SLOTS * PAGE_BYTES;
  localparam int DATA_AW = SLOT_W + OFF_W;

  localparam logic [3:0] FN_READ = 4'd0;
  localparam logic [3:0] FN_WRITE = 4'd1;
  localparam logic [3:0] FN_TICK = 4'd2;
  localparam logic [3:0] FN_FLUSH = 4'd3;
  localparam logic [3:0] FN_INVAL = 4'd4;
  localparam logic [3:0] FN_AGEFULL = 4'd5;
  localparam logic [3:0] FN_FLUSH_ALL = 4'd6;
  localparam logic [3:0] FN_INVAL_ALL = 4'd7;
  localparam logic [3:0] FN_FILL = 4'd8;
  localparam logic [3:0] FN_DRAIN = 4'd9;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_WB = 2'd2;

  localparam logic [0:0] REG_PERIOD = 1'b0;
  localparam logic [0:0] REG_MAX_AGE = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rbyte;
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] page;
    logic hit;
    logic last;
  } result_t;
endpackage

// File: rtl/epwc_ram.sv
module epwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/eeprom_page_writeback_cache_top.sv
// Page cache for a 256-byte-page EEPROM: eight fully associative write-back slots.
// Issue an operation by raising start with func and its operands while busy is low;
// the beat is taken at that edge. The block then emits one or more result beats,
// each on the result ports for exactly one cycle with valid high. Writeback
// requests (result_kind 2) come first, then one final beat with last high, which
// is either a done beat or a fill request (result_kind 1) after a read/write miss.
// The slot lookup takes the cycle after accept. A read hit, drain, fill or
// write hit passes through a data state before its beat shows, because the
// byte store is a single-port RAM with registered read: the lookup cycle
// addresses it and the data cycle presents or writes. Other operations show
// their first beat right after the lookup and then one beat per cycle: one
// per writeback and one for the end, so flush all shows up to nine beats.
// Busy is high from the accept edge until the last beat shows and is low
// while it shows, so the next beat can be taken at the edge that ends it.
// The receiver cannot stall: every beat must be taken when shown.
// Reset clears all tags, valid, dirty and age bits, the aging counter, and sets
// tick_period to 100 and max_age to 10. Byte contents are not cleared; a byte
// never filled or written reads as an unknown value.
// Configuration: cfg_we with cfg_index 0 (tick_period) or 1 (max_age) while idle.
module eeprom_page_writeback_cache_top
  import epwc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [3:0] func,
  input  logic [17:0] byte_address,
  input  logic [7:0] write_byte,
  input  logic [2:0] slot_index,
  input  logic [7:0] byte_offset,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic valid,
  output logic [1:0] result_kind,
  output logic [7:0] read_byte,
  output logic [2:0] slot_out,
  output logic [9:0] page_number,
  output logic hit,
  output logic last
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0] state;
  logic [15:0] tick_period, aging_count;
  logic [7:0] max_age;
  logic [PAGE_W-1:0] tag [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld, drt;
  logic [7:0] age [NUM_SLOTS];

  // Latched operation. For fill and drain the offset is byte_offset.
  logic [3:0] op;
  logic [PAGE_W-1:0] op_page;
  logic [OFF_W-1:0] op_off;
  logic [7:0] op_byte;
  logic [SLOT_W-1:0] op_slot;

  // Byte store port.
  logic ram_we;
  logic [DATA_AW-1:0] ram_addr;
  logic [7:0] ram_wdata, ram_rdata;

  epwc_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Combinational lookup over the latched page.
  logic lk_hit;
  logic [SLOT_W-1:0] lk_slot;
  logic inv_found, cln_found, dty_found;
  logic [SLOT_W-1:0] inv_slot, cln_slot, dty_slot;
  logic [7:0] cln_age;
  always_comb begin
    lk_hit = 1'b0; lk_slot = '0;
    inv_found = 1'b0; inv_slot = '0;
    cln_found = 1'b0; cln_slot = '0; cln_age = '0;
    dty_found = 1'b0; dty_slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (vld[s] && tag[s] == op_page) begin
        lk_hit = 1'b1; lk_slot = SLOT_W'(s);
      end
      if (!vld[s]) begin
        inv_found = 1'b1; inv_slot = SLOT_W'(s);
      end
      if (drt[s]) begin
        dty_found = 1'b1; dty_slot = SLOT_W'(s);
      end
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (!drt[s] && (!cln_found || age[s] >= cln_age)) begin
        cln_found = 1'b1; cln_slot = SLOT_W'(s); cln_age = age[s];
      end
    end
  end

  // Tick: first dirty slot at max age, after the (already applied) aging pass.
  logic full_found;
  logic [SLOT_W-1:0] full_slot;
  always_comb begin
    full_found = 1'b0; full_slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (drt[s] && age[s] == max_age) begin
        full_found = 1'b1; full_slot = SLOT_W'(s);
      end
    end
  end

  result_t res;
  logic res_v;
  assign valid = res_v;
  assign result_kind = res.kind;
  assign read_byte = res.rbyte;
  assign slot_out = res.slot;
  assign page_number = res.page;
  assign hit = res.hit;
  assign last = res.last;
  assign busy = (state != ST_IDLE);

  // The lookup cycle addresses the hit slot for reads and writes, so the byte
  // is ready in the data cycle.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = {op_slot, op_off};
    ram_wdata = op_byte;
    if (state == ST_SCAN) begin
      if (op == FN_READ || op == FN_WRITE) begin
        ram_addr = {lk_slot, op_off};
      end
    end else if (state == ST_DATA) begin
      ram_we = (op == FN_WRITE) || (op == FN_FILL);
    end
  end

  always_ff @(posedge clk) begin
    res_v <= 1'b0;
    if (rst) begin
      state <= ST_IDLE;
      tick_period <= 16'd100;
      max_age <= 8'd10;
      aging_count <= '0;
      vld <= '0;
      drt <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        tag[s] <= '0;
        age[s] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PERIOD: tick_period <= cfg_data;
          REG_MAX_AGE: max_age <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op <= func;
            op_page <= byte_address[17:8];
            op_off <= (func == FN_FILL || func == FN_DRAIN) ? byte_offset
                                                            : byte_address[7:0];
            op_byte <= write_byte;
            op_slot <= slot_index;
            state <= ST_SCAN;
            if (func == FN_TICK) begin
              if (aging_count + 16'd1 == tick_period) begin
                aging_count <= '0;
                for (int s = 0; s < NUM_SLOTS; s++) begin
                  if (age[s] < max_age) age[s] <= age[s] + 8'd1;
                end
              end else begin
                aging_count <= aging_count + 16'd1;
              end
            end
          end
        end
        ST_SCAN: begin
          res <= '{kind: KIND_DONE, rbyte: 8'd0, slot: '0, page: '0, hit: 1'b0,
                   last: 1'b1};
          res_v <= 1'b1;
          state <= ST_IDLE;
          priority case (1'b1)
            (op == FN_READ || op == FN_WRITE): begin
              if (lk_hit) begin
                op_slot <= lk_slot;
                res_v <= 1'b0;
                state <= ST_DATA;
              end else if (inv_found || cln_found) begin
                tag[inv_found ? inv_slot : cln_slot] <= op_page;
                vld[inv_found ? inv_slot : cln_slot] <= 1'b1;
                age[inv_found ? inv_slot : cln_slot] <= '0;
                res.kind <= KIND_FILL;
                res.slot <= inv_found ? inv_slot : cln_slot;
                res.page <= op_page;
              end else begin
                // All slots dirty: write back slot 0, then fill request next cycle.
                res <= '{kind: KIND_WB, rbyte: 8'd0, slot: '0, page: tag[0],
                         hit: 1'b0, last: 1'b0};
                drt[0] <= 1'b0;
                age[0] <= '0;
                state <= ST_SCAN;
              end
            end
            (op == FN_TICK): begin
              if (full_found) begin
                res <= '{kind: KIND_WB, rbyte: 8'd0, slot: full_slot,
                         page: tag[full_slot], hit: 1'b0, last: 1'b0};
                drt[full_slot] <= 1'b0;
                age[full_slot] <= '0;
                op <= 4'hF;
                state <= ST_SCAN;
              end
            end
            (op == FN_FLUSH || op == FN_INVAL || op == FN_AGEFULL): begin
              res.page <= op_page;
              res.hit <= lk_hit;
              res.slot <= lk_hit ? lk_slot : '0;
              if (lk_hit) begin
                if (op != FN_AGEFULL && drt[lk_slot]) begin
                  res.kind <= KIND_WB;
                  res.page <= tag[lk_slot];
                  res.last <= 1'b0;
                  drt[lk_slot] <= 1'b0;
                  age[lk_slot] <= '0;
                  state <= ST_SCAN;
                end else if (op == FN_INVAL) begin
                  vld[lk_slot] <= 1'b0;
                  age[lk_slot] <= '0;
                end else if (op == FN_AGEFULL) begin
                  age[lk_slot] <= max_age;
                end
              end
            end
            (op == FN_FLUSH_ALL || op == FN_INVAL_ALL): begin
              if (dty_found) begin
                res <= '{kind: KIND_WB, rbyte: 8'd0, slot: dty_slot,
                         page: tag[dty_slot], hit: 1'b0, last: 1'b0};
                drt[dty_slot] <= 1'b0;
                age[dty_slot] <= '0;
                state <= ST_SCAN;
              end else if (op == FN_INVAL_ALL) begin
                vld <= '0;
                for (int s = 0; s < NUM_SLOTS; s++) age[s] <= '0;
              end
            end
            (op == FN_FILL || op == FN_DRAIN): begin
              res_v <= 1'b0;
              state <= ST_DATA;
            end
            default: ;
          endcase
        end
        ST_DATA: begin
          state <= ST_IDLE;
          res_v <= 1'b1;
          res <= '{kind: KIND_DONE, rbyte: 8'd0, slot: op_slot, page: '0,
                   hit: 1'b0, last: 1'b1};
          if (op == FN_READ || op == FN_WRITE) begin
            res.page <= op_page;
            res.hit <= 1'b1;
          end
          if (op == FN_READ) begin
            res.rbyte <= ram_rdata;
            if (!drt[op_slot]) age[op_slot] <= '0;
          end else if (op == FN_WRITE) begin
            drt[op_slot] <= 1'b1;
          end else if (op == FN_DRAIN) begin
            res.rbyte <= ram_rdata;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: bench/tb_eeprom_page_writeback_cache_top.sv
`default_nettype none

module tb_eeprom_page_writeback_cache_top
  import epwc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One operation as the host hands it to the cache.
  typedef struct packed {
    logic [3:0]  func;
    logic [17:0] addr;
    logic [7:0]  wbyte;
    logic [2:0]  sidx;
    logic [7:0]  boff;
  } op_t;

  // A row of the directed table: the operation, and optionally the single
  // result beat it must produce, typed in by hand.
  typedef struct packed {
    op_t     op;
    bit      typed;
    result_t want;
  } row_t;

  localparam logic [3:0] FN_UNUSED_LO = 4'd10;
  localparam logic [3:0] FN_UNUSED_HI = 4'd15;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_OPS = 270;
  localparam int QUIET_TAIL = 40;

  logic clk, rst;
  logic start, busy;
  logic [3:0] func;
  logic [17:0] byte_address;
  logic [7:0] write_byte;
  logic [2:0] slot_index;
  logic [7:0] byte_offset;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [15:0] cfg_data;
  logic valid;
  logic [1:0] result_kind;
  logic [7:0] read_byte;
  logic [2:0] slot_out;
  logic [9:0] page_number;
  logic hit, last;

  eeprom_page_writeback_cache_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .byte_address(byte_address), .write_byte(write_byte), .slot_index(slot_index),
    .byte_offset(byte_offset), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .valid(valid), .result_kind(result_kind),
    .read_byte(read_byte), .slot_out(slot_out), .page_number(page_number),
    .hit(hit), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the cache: tags, flags, ages, the aging counter, the byte
  // store and the two registers. The written map tracks which bytes of the
  // store have ever been filled or written, so that no read ever returns a
  // byte the hardware never stored.
  logic [PAGE_W-1:0] sh_tag [NUM_SLOTS];
  bit                sh_valid [NUM_SLOTS];
  bit                sh_dirty [NUM_SLOTS];
  logic [7:0]        sh_age [NUM_SLOTS];
  logic [15:0]       sh_tick_count;
  logic [7:0]        sh_bytes [DATA_DEPTH];
  bit                sh_written [DATA_DEPTH];
  logic [15:0]       sh_period;
  logic [7:0]        sh_max_age;

  // Beats the cache still owes, oldest first.
  result_t pending_beats [$];

  int mismatches = 0;
  int ops_sent = 0;
  int beats_seen = 0;
  int writebacks_seen = 0;
  int fills_seen = 0;
  int watchdog = 0;

  function automatic int find_slot(logic [PAGE_W-1:0] pg);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (sh_valid[s] && sh_tag[s] == pg) return s;
    end
    return -1;
  endfunction

  function automatic void owe(logic [1:0] k, logic [7:0] rb, int s,
                              logic [PAGE_W-1:0] pg, bit h);
    result_t r;
    r.kind = k;
    r.rbyte = rb;
    r.slot = s[SLOT_W-1:0];
    r.page = pg;
    r.hit = h;
    r.last = 1'b0;
    pending_beats.push_back(r);
  endfunction

  function automatic void owe_writeback(int s, bit h);
    owe(KIND_WB, 8'd0, s, sh_tag[s], h);
    sh_dirty[s] = 1'b0;
    sh_age[s] = 8'd0;
  endfunction

  // Works out every beat one operation causes and updates the shadow state.
  // Returns the slot handed out on a read or write miss, or -1.
  function automatic int cache_step(op_t op);
    logic [PAGE_W-1:0] pg;
    logic [OFF_W-1:0] off;
    int s, pick, missed;
    logic [7:0] best;
    logic [DATA_AW-1:0] ix;
    pg = op.addr[17:8];
    off = op.addr[7:0];
    missed = -1;
    case (op.func)
      FN_READ, FN_WRITE: begin
        s = find_slot(pg);
        if (s < 0) begin
          pick = -1;
          for (int i = 0; i < NUM_SLOTS && pick < 0; i++)
            if (!sh_valid[i]) pick = i;
          if (pick < 0) begin
            best = 8'd0;
            for (int i = 0; i < NUM_SLOTS; i++)
              if (!sh_dirty[i] && sh_age[i] >= best) begin
                pick = i;
                best = sh_age[i];
              end
          end
          if (pick < 0) begin
            pick = 0;
            owe_writeback(0, 1'b0);
          end
          sh_tag[pick] = pg;
          sh_valid[pick] = 1'b1;
          sh_dirty[pick] = 1'b0;
          sh_age[pick] = 8'd0;
          owe(KIND_FILL, 8'd0, pick, pg, 1'b0);
          missed = pick;
        end else begin
          ix = {s[SLOT_W-1:0], off};
          if (op.func == FN_READ) begin
            if (!sh_dirty[s]) sh_age[s] = 8'd0;
            owe(KIND_DONE, sh_bytes[ix], s, pg, 1'b1);
          end else begin
            sh_bytes[ix] = op.wbyte;
            sh_written[ix] = 1'b1;
            sh_dirty[s] = 1'b1;
            owe(KIND_DONE, 8'd0, s, pg, 1'b1);
          end
        end
      end
      FN_TICK: begin
        sh_tick_count = sh_tick_count + 16'd1;
        if (sh_tick_count == sh_period) begin
          sh_tick_count = 16'd0;
          for (int i = 0; i < NUM_SLOTS; i++)
            if (sh_age[i] < sh_max_age) sh_age[i] = sh_age[i] + 8'd1;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
          if (sh_dirty[i] && sh_age[i] == sh_max_age) begin
            owe_writeback(i, 1'b0);
            break;
          end
        owe(KIND_DONE, 8'd0, 0, '0, 1'b0);
      end
      FN_FLUSH, FN_INVAL, FN_AGEFULL: begin
        s = find_slot(pg);
        if (s >= 0) begin
          if (op.func != FN_AGEFULL && sh_dirty[s]) owe_writeback(s, 1'b1);
          if (op.func == FN_INVAL) begin
            sh_valid[s] = 1'b0;
            sh_dirty[s] = 1'b0;
            sh_age[s] = 8'd0;
          end else if (op.func == FN_AGEFULL) begin
            sh_age[s] = sh_max_age;
          end
        end
        owe(KIND_DONE, 8'd0, (s >= 0) ? s : 0, pg, s >= 0);
      end
      FN_FLUSH_ALL, FN_INVAL_ALL: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (sh_dirty[i]) owe_writeback(i, 1'b0);
          if (op.func == FN_INVAL_ALL) begin
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_age[i] = 8'd0;
          end
        end
        owe(KIND_DONE, 8'd0, 0, '0, 1'b0);
      end
      FN_FILL, FN_DRAIN: begin
        // Slot and offset fields are exactly as wide as the cache, so they
        // always land inside it.
        ix = {op.sidx, op.boff};
        if (op.func == FN_FILL) begin
          sh_bytes[ix] = op.wbyte;
          sh_written[ix] = 1'b1;
          owe(KIND_DONE, 8'd0, op.sidx, '0, 1'b0);
        end else begin
          owe(KIND_DONE, sh_bytes[ix], op.sidx, '0, 1'b0);
        end
      end
      default: owe(KIND_DONE, 8'd0, 0, '0, 1'b0);
    endcase
    pending_beats[$].last = 1'b1;
    return missed;
  endfunction

  // Presents one operation and holds it until the cache takes the beat.
  // Called right after a rising edge; returns right after the accepting edge,
  // with start still high so that a following beat can go out back to back.
  task automatic issue(input op_t op, output int missed);
    bit taken;
    func <= op.func;
    byte_address <= op.addr;
    write_byte <= op.wbyte;
    slot_index <= op.sidx;
    byte_offset <= op.boff;
    start <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    missed = cache_step(op);
    ops_sent++;
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Registers only change with the cache idle: hold off until every owed beat
  // is in, let the pipeline settle, then write.
  task automatic write_reg(logic [0:0] idx, logic [15:0] value);
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PERIOD) sh_period = value;
    else sh_max_age = value[7:0];
  endtask

  // Result beats are sampled mid-cycle, where every output is settled.
  always @(negedge clk) begin
    result_t got, want;
    if (!rst && valid) begin
      got = '{result_kind, read_byte, slot_out, page_number, hit, last};
      beats_seen++;
      if (got.kind == KIND_WB) writebacks_seen++;
      if (got.kind == KIND_FILL) fills_seen++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: beat with nothing owed: kind %0d byte %02h slot %0d page %0d hit %0d last %0d",
                   $realtime, got.kind, got.rbyte, got.slot, got.page, got.hit, got.last);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: beat mismatch: want kind %0d byte %02h slot %0d page %0d hit %0d last %0d, got kind %0d byte %02h slot %0d page %0d hit %0d last %0d",
                     $realtime, want.kind, want.rbyte, want.slot, want.page, want.hit,
                     want.last, got.kind, got.rbyte, got.slot, got.page, got.hit, got.last);
        end
      end
    end
  end

  // The watchdog counts cycles in which neither an operation nor a result
  // beat moves. Register writes and the idle bursts are far shorter.
  always @(negedge clk) begin
    if (rst || valid || (start && !busy)) begin
      watchdog <= 0;
    end else if (watchdog >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  // The directed part walks the special cases in order: a miss and its fill,
  // hits on both ends of the address space, aging to the limit, flush and
  // invalidate with and without dirty data, the whole-cache operations, and
  // an unused function code.
  localparam result_t NO_CHECK = '0;
  row_t dir_rows [22] = '{
    '{'{FN_READ,      18'h3FFFF, 8'h00, 3'd0, 8'd0},   1, '{KIND_FILL, 8'h00, 3'd0, 10'd1023, 1'b0, 1'b1}},
    '{'{FN_FILL,      18'h00000, 8'hFF, 3'd0, 8'd255}, 1, '{KIND_DONE, 8'h00, 3'd0, 10'd0, 1'b0, 1'b1}},
    '{'{FN_READ,      18'h3FFFF, 8'h00, 3'd0, 8'd0},   1, '{KIND_DONE, 8'hFF, 3'd0, 10'd1023, 1'b1, 1'b1}},
    '{'{FN_WRITE,     18'h00000, 8'h00, 3'd0, 8'd0},   1, '{KIND_FILL, 8'h00, 3'd1, 10'd0, 1'b0, 1'b1}},
    '{'{FN_WRITE,     18'h00000, 8'h00, 3'd0, 8'd0},   0, NO_CHECK},
    '{'{FN_DRAIN,     18'h00000, 8'h00, 3'd1, 8'd0},   0, NO_CHECK},
    '{'{FN_FILL,      18'h00000, 8'h00, 3'd7, 8'd0},   0, NO_CHECK},
    '{'{FN_DRAIN,     18'h00000, 8'h00, 3'd7, 8'd0},   0, NO_CHECK},
    '{'{FN_TICK,      18'h00000, 8'h00, 3'd0, 8'd0},   1, '{KIND_DONE, 8'h00, 3'd0, 10'd0, 1'b0, 1'b1}},
    '{'{FN_AGEFULL,   18'h00000, 8'h00, 3'd0, 8'd0},   1, '{KIND_DONE, 8'h00, 3'd1, 10'd0, 1'b1, 1'b1}},
    '{'{FN_TICK,      18'h00000, 8'h00, 3'd0, 8'd0},   0, NO_CHECK},
    '{'{FN_FLUSH,     18'h00000, 8'h00, 3'd0, 8'd0},   0, NO_CHECK},
    '{'{FN_WRITE,     18'h00005, 8'hAA, 3'd0, 8'd0},   0, NO_CHECK},
    '{'{FN_FLUSH,     18'h00005, 8'h00, 3'd0, 8'd0},   0, NO_CHECK},
    '{'{FN_WRITE,     18'h00005, 8'h55, 3'd0, 8'd0},   0, NO_CHECK},
    '{'{FN_INVAL,     18'h00005, 8'h00, 3'd0, 8'd0},   0, NO_CHECK},
    '{'{FN_INVAL,     18'h00000, 8'h00, 3'd0, 8'd0},   1, '{KIND_DONE, 8'h00, 3'd0, 10'd0, 1'b0, 1'b1}},
    '{'{FN_FLUSH,     18'h2AAAA, 8'h00, 3'd0, 8'd0},   1, '{KIND_DONE, 8'h00, 3'd0, 10'h2AA, 1'b0, 1'b1}},
    '{'{FN_WRITE,     18'h3FF00, 8'h5A, 3'd0, 8'd0},   0, NO_CHECK},
    '{'{FN_FLUSH_ALL, 18'h00000, 8'h00, 3'd0, 8'd0},   0, NO_CHECK},
    '{'{FN_INVAL_ALL, 18'h00000, 8'h00, 3'd0, 8'd0},   0, NO_CHECK},
    '{'{FN_UNUSED_HI, 18'h3FFFF, 8'hFF, 3'd7, 8'd255}, 1, '{KIND_DONE, 8'h00, 3'd0, 10'd0, 1'b0, 1'b1}}
  };

  // Pages that the random part keeps coming back to, so that slots fill up,
  // go dirty and get evicted; a tenth of the addresses fall anywhere.
  logic [PAGE_W-1:0] hot_pages [12];

  function automatic op_t random_op();
    op_t op;
    int pick, s;
    logic [DATA_AW-1:0] ix;
    pick = $urandom_range(0, 99);
    op.wbyte = 8'($urandom);
    op.sidx = 3'($urandom);
    op.boff = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    op.addr = {hot_pages[$urandom_range(0, 11)],
               ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom)};
    if ($urandom_range(0, 9) == 0) op.addr = 18'($urandom);
    if (pick < 28) op.func = FN_READ;
    else if (pick < 56) op.func = FN_WRITE;
    else if (pick < 68) op.func = FN_TICK;
    else if (pick < 76) op.func = FN_FILL;
    else if (pick < 82) op.func = FN_DRAIN;
    else if (pick < 86) op.func = FN_FLUSH;
    else if (pick < 89) op.func = FN_INVAL;
    else if (pick < 94) op.func = FN_AGEFULL;
    else if (pick < 96) op.func = FN_FLUSH_ALL;
    else if (pick < 98) op.func = FN_INVAL_ALL;
    else op.func = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
    // A read that would hit a byte never stored becomes the fill of that byte;
    // a drain of such a byte likewise.
    if (op.func == FN_READ) begin
      s = find_slot(op.addr[17:8]);
      if (s >= 0) begin
        ix = {s[SLOT_W-1:0], op.addr[7:0]};
        if (!sh_written[ix]) begin
          op.func = FN_FILL;
          op.sidx = s[SLOT_W-1:0];
          op.boff = op.addr[7:0];
        end
      end
    end else if (op.func == FN_DRAIN && !sh_written[{op.sidx, op.boff}]) begin
      op.func = FN_FILL;
    end
    return op;
  endfunction

  initial begin
    int missed, dummy, sent;
    bit quiet;
    op_t op, fill_op;
    logic [15:0] periods [5];
    logic [7:0] ages [5];

    periods = '{16'd1, 16'd3, 16'd65535, 16'd2, 16'd1};
    ages = '{8'd1, 8'd255, 8'd10, 8'd4, 8'd2};
    rst = 1'b1;
    start = 1'b0;
    func = '0;
    byte_address = '0;
    write_byte = '0;
    slot_index = '0;
    byte_offset = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sh_period = 16'd100;
    sh_max_age = 8'd10;
    sh_tick_count = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sh_tag[i] = '0;
      sh_valid[i] = 1'b0;
      sh_dirty[i] = 1'b0;
      sh_age[i] = '0;
    end
    for (int i = 0; i < DATA_DEPTH; i++) begin
      sh_bytes[i] = '0;
      sh_written[i] = 1'b0;
    end
    foreach (hot_pages[i]) hot_pages[i] = PAGE_W'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows. Where a row carries its own answer it replaces the
    // computed one, so the hand-typed value is what the hardware faces.
    foreach (dir_rows[i]) begin
      issue(dir_rows[i].op, dummy);
      if (dir_rows[i].typed) pending_beats[$] = dir_rows[i].want;
    end

    // Random phases, each under its own register setting. Most misses are
    // followed by the host doing its part: a fill of the byte and a retry.
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_PERIOD, periods[ph]);
      write_reg(REG_MAX_AGE, {8'd0, ages[ph]});
      for (int k = 0; k < RANDOM_OPS / 5; k++) begin
        quiet = (sent >= RANDOM_OPS - QUIET_TAIL);
        if (!quiet && $urandom_range(0, 5) == 0) pause($urandom_range(1, 11));
        op = random_op();
        issue(op, missed);
        sent++;
        if (missed >= 0 && $urandom_range(0, 9) < 7) begin
          fill_op = op;
          fill_op.func = FN_FILL;
          fill_op.sidx = missed[SLOT_W-1:0];
          fill_op.boff = op.addr[7:0];
          fill_op.wbyte = 8'($urandom);
          if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 11));
          issue(fill_op, dummy);
          issue(op, dummy);
        end
      end
    end

    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d operations, %0d result beats, %0d writebacks, %0d fill requests,",
             ops_sent, beats_seen, writebacks_seen, fills_seen);
    $display("across five register settings including both period and age extremes.");
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
